// ===== rtl/core/m2r_pkg.sv =====
// Shared types, widths and constants for the masked polar-to-rectangular converter.
// Holds the CORDIC angle table, the fixed-point constants and the saturation helper.
// No dependencies.
package m2r_pkg;

    localparam int SAMPLE_WIDTH    = 16;
    localparam int ROT_STAGES      = 16;
    localparam int STG_W           = (ROT_STAGES > 1) ? $clog2(ROT_STAGES) : 1;

    // scaled product width before clipping to 32 bits
    localparam int PROD_W          = SAMPLE_WIDTH + 16;

    localparam int FRAC_EXTRA      = 16;
    localparam int XW              = 50;   // CORDIC x/y datapath
    localparam int ZW              = 34;   // residual angle

    // about 2^39/pi: Q24.8 radians -> 32-bit binary angle (bits 16..47)
    localparam logic [47:0] PHASE_K   = 48'd174992710548;
    // 1/gain in Q0.16
    localparam logic signed [16:0] INV_GAIN = 17'sd39797;

    // configuration register indexes
    localparam logic [1:0] REG_POLAR_MODE   = 2'd0;
    localparam logic [1:0] REG_FIRST_SCALE  = 2'd1;
    localparam logic [1:0] REG_SECOND_SCALE = 2'd2;

    localparam logic signed [15:0] SCALE_ONE = 16'sd256;

    // atan(2^-i) in binary angle units (2^32 per turn)
    localparam logic [31:0] ATAN_TBL [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    typedef struct packed {
        logic               polar;
        logic               keep;
        logic signed [31:0] a;
        logic signed [31:0] b;
    } m2r_side_t;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } m2r_rot_t;

    function automatic logic signed [31:0] m2r_sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/m2r_front.sv =====
// Front end: scaling multiply, phase-to-angle multiply, quadrant fold.
// Three handshaked stages feeding the CORDIC cell chain. Uses m2r_pkg.
module m2r_front (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    polar_mode,
    input  logic signed [15:0]                      first_scale,
    input  logic signed [15:0]                      second_scale,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic signed [m2r_pkg::SAMPLE_WIDTH-1:0] first_raw,
    input  logic signed [m2r_pkg::SAMPLE_WIDTH-1:0] second_raw,
    input  logic                                    keep_voxel,
    output logic                                    dn_valid,
    input  logic                                    dn_ready,
    output m2r_pkg::m2r_rot_t                       dn_rot,
    output m2r_pkg::m2r_side_t                      dn_side
);
    import m2r_pkg::*;

    logic               vld0_reg, vld1_reg, vld2_reg;
    logic               rdy0, rdy1, rdy2;
    m2r_side_t          side0_reg, side0_next;
    m2r_side_t          side1_reg, side2_reg;
    logic [47:0]        plo_reg, plo_next;
    logic [31:0]        phi_reg, phi_next;
    logic signed [47:0] xm_reg, xm_next;
    m2r_rot_t           rot2_reg, rot2_next;

    logic signed [15:0]     s1_eff, s2_eff;
    logic signed [PROD_W-1:0] pa, pb;
    logic [47:0]            ang_sum;
    logic signed [31:0]     ang;
    logic signed [ZW-1:0]   z0;
    logic signed [XW-1:0]   x0;

    assign rdy2     = ~vld2_reg | dn_ready;
    assign rdy1     = ~vld1_reg | rdy2;
    assign rdy0     = ~vld0_reg | rdy1;
    assign s_ready  = rdy0;
    assign dn_valid = vld2_reg;
    assign dn_rot   = rot2_reg;
    assign dn_side  = side2_reg;

    // stage 0: scale both components (zero scale means 1.0)
    always_comb begin
        s1_eff = (first_scale == 16'sd0) ? SCALE_ONE : first_scale;
        s2_eff = (second_scale == 16'sd0) ? SCALE_ONE : second_scale;
        pa = first_raw * s1_eff;
        pb = second_raw * s2_eff;
        side0_next.polar = polar_mode;
        side0_next.keep  = keep_voxel;
        side0_next.a     = m2r_sat32(64'(pa));
        side0_next.b     = m2r_sat32(64'(pb));
    end

    // stage 1: phase * PHASE_K split in two partial products, magnitude * 1/gain
    always_comb begin
        plo_next = 48'(side0_reg.b[15:0]) * PHASE_K;
        phi_next = {{16{side0_reg.b[31]}}, side0_reg.b[31:16]} * PHASE_K[31:0];
        xm_next  = side0_reg.a * INV_GAIN;
    end

    // stage 2: binary angle, fold into [-quarter, +quarter] turn
    always_comb begin
        ang_sum = plo_reg + {phi_reg, 16'd0};
        ang     = ang_sum[47:16];
        z0      = ZW'(ang);
        x0      = XW'(xm_reg);
        rot2_next.y = '0;
        if (ang > 32'sd1073741824) begin
            rot2_next.z = z0 - (ZW'(1) <<< 31);
            rot2_next.x = -x0;
        end else if (ang < -32'sd1073741824) begin
            rot2_next.z = z0 + (ZW'(1) <<< 31);
            rot2_next.x = -x0;
        end else begin
            rot2_next.z = z0;
            rot2_next.x = x0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld0_reg <= 1'b0;
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end else begin
            if (rdy0) begin
                vld0_reg <= s_valid;
            end
            if (rdy1) begin
                vld1_reg <= vld0_reg;
            end
            if (rdy2) begin
                vld2_reg <= vld1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy0 && s_valid) begin
            side0_reg <= side0_next;
        end
        if (rdy1 && vld0_reg) begin
            side1_reg <= side0_reg;
            plo_reg   <= plo_next;
            phi_reg   <= phi_next;
            xm_reg    <= xm_next;
        end
        if (rdy2 && vld1_reg) begin
            side2_reg <= side1_reg;
            rot2_reg  <= rot2_next;
        end
    end

endmodule

// ===== rtl/core/m2r_cell.sv =====
// One CORDIC rotation cell: a micro-rotation by +-atan(2^-k) per transaction.
// Cells are chained; stage_idx is tied to a constant per instance. Uses m2r_pkg.
module m2r_cell (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [m2r_pkg::STG_W-1:0] stage_idx,
    input  logic                      up_valid,
    output logic                      up_ready,
    input  m2r_pkg::m2r_rot_t         up_rot,
    input  m2r_pkg::m2r_side_t        up_side,
    output logic                      dn_valid,
    input  logic                      dn_ready,
    output m2r_pkg::m2r_rot_t         dn_rot,
    output m2r_pkg::m2r_side_t        dn_side
);
    import m2r_pkg::*;

    logic                 vld_reg;
    m2r_rot_t             rot_reg, rot_next;
    m2r_side_t            side_reg;
    logic signed [XW-1:0] xi, yi, dx, dy;
    logic signed [ZW-1:0] zi, da;

    assign up_ready = ~vld_reg | dn_ready;
    assign dn_valid = vld_reg;
    assign dn_rot   = rot_reg;
    assign dn_side  = side_reg;

    always_comb begin
        xi = up_rot.x;
        yi = up_rot.y;
        zi = up_rot.z;
        dx = yi >>> stage_idx;
        dy = xi >>> stage_idx;
        da = ZW'(ATAN_TBL[5'(stage_idx)]);
        if (!zi[ZW-1]) begin
            rot_next.x = xi - dx;
            rot_next.y = yi + dy;
            rot_next.z = zi - da;
        end else begin
            rot_next.x = xi + dx;
            rot_next.y = yi - dy;
            rot_next.z = zi + da;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (up_ready) begin
            vld_reg <= up_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (up_ready && up_valid) begin
            rot_reg  <= rot_next;
            side_reg <= up_side;
        end
    end

endmodule

// ===== rtl/core/m2r_back.sv =====
// Back end: round and clip the CORDIC outputs, pick mode, apply mask.
// Holds the output register of the result channel. Uses m2r_pkg.
module m2r_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               up_valid,
    output logic               up_ready,
    input  m2r_pkg::m2r_rot_t  up_rot,
    input  m2r_pkg::m2r_side_t up_side,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_out_real,
    output logic signed [31:0] m_out_imag
);
    import m2r_pkg::*;

    localparam int RW = XW - FRAC_EXTRA;

    logic                 vld_reg;
    logic signed [31:0]   re_reg, re_next;
    logic signed [31:0]   im_reg, im_next;
    logic signed [XW-1:0] xr, yr;
    logic signed [RW-1:0] xs, ys;

    assign up_ready   = ~vld_reg | m_ready;
    assign m_valid    = vld_reg;
    assign m_out_real = re_reg;
    assign m_out_imag = im_reg;

    always_comb begin
        xr = up_rot.x + (XW'(1) <<< (FRAC_EXTRA - 1));
        yr = up_rot.y + (XW'(1) <<< (FRAC_EXTRA - 1));
        xs = RW'(xr >>> FRAC_EXTRA);
        ys = RW'(yr >>> FRAC_EXTRA);
        if (!up_side.keep) begin
            re_next = '0;
            im_next = '0;
        end else if (up_side.polar) begin
            re_next = m2r_sat32(64'(xs));
            im_next = m2r_sat32(64'(ys));
        end else begin
            re_next = up_side.a;
            im_next = up_side.b;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (up_ready) begin
            vld_reg <= up_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (up_ready && up_valid) begin
            re_reg <= re_next;
            im_reg <= im_next;
        end
    end

endmodule

// ===== rtl/core/masked_polar_to_rectangular.sv =====
// Top level of the masked polar-to-rectangular voxel converter.
// Instantiates m2r_front, a chain of m2r_cell and m2r_back; uses m2r_pkg.
//
// Usage:
//   Input channel (s_*): one voxel per transaction, two signed raw components
//   and a keep bit. Result channel (m_*): one Q24.8 pair per voxel, in order.
//   Both channels are valid/ready; every stage has its own valid flag and
//   takes new data whenever it is empty or its successor takes its data.
//   APB port: polar_mode at 0x0, first_scale at 0x4, second_scale at 0x8.
//   Registers are read live, so write them only while the block is drained.
// Pipeline: 3 front-end stages (scale multiply, angle multiply, quadrant
//   fold), ROT_STAGES CORDIC cells (16) and one output register.
// Throughput: one transaction per cycle while m_ready stays high, set by the
//   one-cell-per-rotation pipeline; every stage is a single register.
// Reset: aresetn (synchronous, active low) empties the pipeline and returns
//   polar_mode to 0 and both scales to 256 (1.0).
// Receiver stall: with m_ready low the output register holds; stages behind
//   it keep filling until each holds a transaction, then s_ready falls.
module masked_polar_to_rectangular (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    // APB configuration port
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [3:0]                              paddr,
    input  logic [31:0]                             pwdata,
    output logic [31:0]                             prdata,
    output logic                                    pready,
    // input channel
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic signed [m2r_pkg::SAMPLE_WIDTH-1:0] s_first_raw,
    input  logic signed [m2r_pkg::SAMPLE_WIDTH-1:0] s_second_raw,
    input  logic                                    s_keep_voxel,
    // result channel
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic signed [31:0]                      m_out_real,
    output logic signed [31:0]                      m_out_imag
);
    import m2r_pkg::*;

    logic               polar_mode_reg;
    logic signed [15:0] first_scale_reg;
    logic signed [15:0] second_scale_reg;
    logic               wr_en;
    logic [1:0]         reg_idx;

    // chain links: index 0 is the front-end output, ROT_STAGES feeds the back end
    logic      lnk_vld  [ROT_STAGES+1];
    logic      lnk_rdy  [ROT_STAGES+1];
    m2r_rot_t  lnk_rot  [ROT_STAGES+1];
    m2r_side_t lnk_side [ROT_STAGES+1];

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel & penable & pwrite & pready;

    // register write; unknown addresses are ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            polar_mode_reg   <= 1'b0;
            first_scale_reg  <= SCALE_ONE;
            second_scale_reg <= SCALE_ONE;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_POLAR_MODE:   polar_mode_reg   <= pwdata[0];
                REG_FIRST_SCALE:  first_scale_reg  <= pwdata[15:0];
                REG_SECOND_SCALE: second_scale_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (reg_idx)
            REG_POLAR_MODE:   prdata = {31'd0, polar_mode_reg};
            REG_FIRST_SCALE:  prdata = {16'd0, first_scale_reg};
            REG_SECOND_SCALE: prdata = {16'd0, second_scale_reg};
            default:          prdata = '0;
        endcase
    end

    m2r_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .polar_mode   (polar_mode_reg),
        .first_scale  (first_scale_reg),
        .second_scale (second_scale_reg),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .first_raw    (s_first_raw),
        .second_raw   (s_second_raw),
        .keep_voxel   (s_keep_voxel),
        .dn_valid     (lnk_vld[0]),
        .dn_ready     (lnk_rdy[0]),
        .dn_rot       (lnk_rot[0]),
        .dn_side      (lnk_side[0])
    );

    // one micro-rotation per cell, shift amount equals cell position
    for (genvar g = 0; g < ROT_STAGES; g++) begin : g_cell
        m2r_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .stage_idx (STG_W'(g)),
            .up_valid  (lnk_vld[g]),
            .up_ready  (lnk_rdy[g]),
            .up_rot    (lnk_rot[g]),
            .up_side   (lnk_side[g]),
            .dn_valid  (lnk_vld[g+1]),
            .dn_ready  (lnk_rdy[g+1]),
            .dn_rot    (lnk_rot[g+1]),
            .dn_side   (lnk_side[g+1])
        );
    end

    m2r_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .up_valid   (lnk_vld[ROT_STAGES]),
        .up_ready   (lnk_rdy[ROT_STAGES]),
        .up_rot     (lnk_rot[ROT_STAGES]),
        .up_side    (lnk_side[ROT_STAGES]),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_real (m_out_real),
        .m_out_imag (m_out_imag)
    );

endmodule
